// ----- sv/rfr_pkg.sv -----
// Package for the rational fraction reducer.
// Holds the result status codes shared by the top level and the checker.
// No dependencies.
package rfr_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_MOST_NEG = 2'd2
  } status_e;

endpackage

// ----- sv/rfr_if.sv -----
// Valid/ready channel interfaces for the fraction reducer.
// rfr_in_if carries the operands, rfr_out_if the reduced fraction and status.
// Uses rfr_pkg for the status type.
interface rfr_in_if #(
  parameter int WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] numerator_in;
  logic signed [WIDTH-1:0] denominator_in;

  modport source (output valid, output numerator_in, output denominator_in, input ready);
  modport sink   (input valid, input numerator_in, input denominator_in, output ready);
endinterface

interface rfr_out_if #(
  parameter int WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] reduced_numerator;
  logic        [WIDTH-2:0] reduced_denominator;
  rfr_pkg::status_e        status;

  modport source (output valid, output reduced_numerator, output reduced_denominator,
                  output status, input ready);
  modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                  input status, output ready);
endinterface

// ----- sv/rational_fraction_reducer.sv -----
// Top level of the rational fraction reducer: sequencer around one shared divider.
// Depends on rfr_pkg, rfr_if.sv and rfr_div.
//
//   channel | dir | payload                                              | handshake
//   in_i    | in  | numerator_in, denominator_in                         | valid/ready
//   out_o   | out | reduced_numerator, reduced_denominator, status       | valid/ready
//
// One item at a time. Every division goes through the shared divider; an item runs
// the Euclid remainder steps, then divides the numerator and denominator magnitudes
// by the gcd, before its output transaction.
// Errored operands skip the divider and go straight to the done state.
// in_i.ready is high only when the sequencer is idle; a finished result waits in the
// output register while a new item is taken, and the sequencer holds if it is still full.
// Asynchronous active-low reset clears the sequencer and the output valid.
module rational_fraction_reducer #(
  parameter int WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  rfr_in_if.sink    in_i,
  rfr_out_if.source out_o
);

  localparam int M = WIDTH - 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIVN = 3'd2;
  localparam logic [2:0] S_DIVD = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {M{1'b0}}};

  logic [2:0]       state_q, state_d;
  logic [M-1:0]     a_q, a_d;
  logic [M-1:0]     b_q, b_d;
  logic [M-1:0]     an_q, an_d;
  logic [M-1:0]     ad_q, ad_d;
  logic [M-1:0]     rn_q, rn_d;
  logic             sgn_q, sgn_d;
  logic [WIDTH-1:0] res_num_q, res_num_d;
  logic [M-1:0]     res_den_q, res_den_d;
  rfr_pkg::status_e res_st_q, res_st_d;
  logic             ovalid_q, ovalid_d;
  logic [WIDTH-1:0] onum_q;
  logic [M-1:0]     oden_q;
  rfr_pkg::status_e ost_q;

  logic             div_start;
  logic [M-1:0]     div_dvd, div_dvs;
  logic             div_done;
  logic [M-1:0]     div_quot, div_rem;

  logic [WIDTH-1:0] n_in, d_in, n_abs, d_abs;
  logic             in_acc, out_load;
  logic [WIDTH-1:0] rn_ext;

  assign n_in   = in_i.numerator_in;
  assign d_in   = in_i.denominator_in;
  assign n_abs  = n_in[WIDTH-1] ? (~n_in + 1'b1) : n_in;
  assign d_abs  = d_in[WIDTH-1] ? (~d_in + 1'b1) : d_in;
  assign in_acc = in_i.valid && in_i.ready;
  assign out_load = (state_q == S_DONE) && (!ovalid_q || out_o.ready);
  assign rn_ext = {1'b0, rn_q};

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    an_d      = an_q;
    ad_d      = ad_q;
    rn_d      = rn_q;
    sgn_d     = sgn_q;
    res_num_d = res_num_q;
    res_den_d = res_den_q;
    res_st_d  = res_st_q;
    div_start = 1'b0;
    div_dvd   = a_q;
    div_dvs   = b_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_num_d = '0;
          res_den_d = '0;
          if (d_in == '0) begin
            res_st_d = rfr_pkg::ST_ZERO_DEN;
            state_d  = S_DONE;
          end else if (n_in == MOST_NEG || d_in == MOST_NEG) begin
            res_st_d = rfr_pkg::ST_MOST_NEG;
            state_d  = S_DONE;
          end else begin
            an_d      = n_abs[M-1:0];
            ad_d      = d_abs[M-1:0];
            a_d       = n_abs[M-1:0];
            b_d       = d_abs[M-1:0];
            sgn_d     = n_in[WIDTH-1] ^ d_in[WIDTH-1];
            div_start = 1'b1;
            div_dvd   = n_abs[M-1:0];
            div_dvs   = d_abs[M-1:0];
            state_d   = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (div_done) begin
          div_start = 1'b1;
          if (div_rem == '0) begin
            // b holds the gcd; divide the numerator magnitude by it
            div_dvd = an_q;
            div_dvs = b_q;
            state_d = S_DIVN;
          end else begin
            a_d     = b_q;
            b_d     = div_rem;
            div_dvd = b_q;
            div_dvs = div_rem;
          end
        end
      end
      S_DIVN: begin
        if (div_done) begin
          rn_d      = div_quot;
          div_start = 1'b1;
          div_dvd   = ad_q;
          div_dvs   = b_q;
          state_d   = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          res_num_d = (sgn_q && rn_q != '0) ? (~rn_ext + 1'b1) : rn_ext;
          res_den_d = div_quot;
          res_st_d  = rfr_pkg::ST_OK;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
    if (out_load) begin
      ovalid_d = 1'b1;
    end
  end

  rfr_div #(
    .M (M)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    an_q      <= an_d;
    ad_q      <= ad_d;
    rn_q      <= rn_d;
    sgn_q     <= sgn_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      onum_q <= res_num_q;
      oden_q <= res_den_q;
      ost_q  <= res_st_q;
    end
  end

  assign out_o.valid               = ovalid_q;
  assign out_o.reduced_numerator   = onum_q;
  assign out_o.reduced_denominator = oden_q;
  assign out_o.status              = ost_q;

endmodule

// ----- sv/rfr_div.sv -----
// Shared restoring divider: one quotient bit per cycle.
// Used by the sequencer for every Euclid remainder and both final divisions.
// No package dependencies.
module rfr_div #(
  parameter int M = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [M-1:0] dividend_i,
  input  logic [M-1:0] divisor_i,
  output logic         done_o,
  output logic [M-1:0] quot_o,
  output logic [M-1:0] rem_o
);

  localparam int CW = $clog2(M);
  localparam logic [CW-1:0] LAST = CW'(M - 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [M-1:0]  rem_q, rem_d;
  logic [M-1:0]  quo_q, quo_d;
  logic [M-1:0]  dvs_q, dvs_d;
  logic [M:0]    trial;
  logic [M:0]    diff;
  logic          ge;

  assign trial = {rem_q, quo_q[M-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[M-1:0] : trial[M-1:0];
      quo_d = {quo_q[M-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- sv/rfr_checker.sv -----
// Port-level checker for the fraction reducer, bound to the top level.
// Depends on rfr_pkg and rational_fraction_reducer.
module rfr_checker #(
  parameter int WIDTH = 32
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [WIDTH-1:0] num_i,
  input logic        [WIDTH-2:0] den_i,
  input rfr_pkg::status_e        status_i
);

  // one item in flight: no second transaction straight after an accepted one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken on the cycle after a transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(num_i) && $stable(den_i)
                                    && $stable(status_i))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != rfr_pkg::ST_OK |-> num_i == '0 && den_i == '0)
    else $error("error result with nonzero fraction");

  a_ok_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == rfr_pkg::ST_OK |-> den_i != '0)
    else $error("valid fraction with zero denominator");

endmodule

bind rational_fraction_reducer rfr_checker #(.WIDTH(WIDTH)) u_rfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .num_i       (out_o.reduced_numerator),
  .den_i       (out_o.reduced_denominator),
  .status_i    (out_o.status)
);
